>>> rtl/plid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and codes of the positional list unit: request and result
// layouts, command and status codes, and the beat passed to the result stage.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_BADCMD   = 3'd5;

    typedef struct packed {
        logic [2:0]         command;
        logic [6:0]         position;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         found_position;
        logic signed [31:0] element_value;
        logic [6:0]         list_count;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic               elem;
        logic               fin;
        logic               hit;
        logic [2:0]         status;
        logic [6:0]         position;
        logic signed [31:0] value;
        logic [6:0]         count;
    } beat_t;

endpackage

>>> rtl/plid_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_emit
// Result stage: turns beats from the sequencer into registered results, and
// holds back the latest match of a scan so the final one carries last_result.
// ----------------------------------------------------------------------------
module plid_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  plid_pkg::beat_t   beat,
    output logic              done,
    output plid_pkg::result_t result
);

    logic              done_reg;
    logic              done_next;
    plid_pkg::result_t result_reg;
    plid_pkg::result_t result_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    plid_pkg::result_t pend_reg;
    plid_pkg::result_t pend_next;

    always_comb
    begin
        done_next       = 1'b0;
        result_next     = result_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (beat.valid)
        begin
            priority if (beat.elem)
            begin
                if (beat.hit)
                begin
                    if (pend_valid_reg)
                    begin
                        done_next               = 1'b1;
                        result_next             = pend_reg;
                        result_next.last_result = 1'b0;
                    end
                    pend_next.status         = plid_pkg::ST_OK;
                    pend_next.found_position = beat.position;
                    pend_next.element_value  = beat.value;
                    pend_next.list_count     = beat.count;
                    pend_next.last_result    = 1'b0;
                    pend_valid_next          = 1'b1;
                end
            end
            else if (beat.fin)
            begin
                done_next = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next             = pend_reg;
                    result_next.last_result = 1'b1;
                end
                else
                begin
                    result_next.status         = beat.status;
                    result_next.found_position = 7'd0;
                    result_next.element_value  = 32'sd0;
                    result_next.list_count     = beat.count;
                    result_next.last_result    = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            else
            begin
                done_next                  = 1'b1;
                result_next.status         = beat.status;
                result_next.found_position = beat.position;
                result_next.element_value  = beat.value;
                result_next.list_count     = beat.count;
                result_next.last_result    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        pend_reg   <= pend_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/positional_list_insert_delete_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_search_unit
// Ordered list of up to DEPTH signed 32-bit values in one synchronous memory,
// with clear, insert, delete, search and read-all requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Clear, refused
// requests and bad commands leave busy low. Insert at position n+1 of a
// list of n entries moves nothing; otherwise insert and delete move, and
// search and read-all read, one entry per cycle through the memory's single
// read port and single write port; the memory read is registered and each
// request ends with a finishing step. Results appear on result, marked by
// done, at most one per cycle and in the cycle after the step that makes
// them; a scan holds each reported element back until the next one or the
// end of the scan, so the final one can carry last_result. Results cannot be
// held off, so capture every cycle done is high. last_result marks the final
// result of each request.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_search_unit #(
    parameter int DEPTH = plid_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  plid_pkg::request_t request,
    output logic               done,
    output plid_pkg::result_t  result
);

    localparam int AW   = $clog2(DEPTH);
    localparam int AW1  = AW + 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UP   = 4'b0010,
        S_DOWN = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [AW-1:0]    raddr_reg;
    logic [AW-1:0]    raddr_next;
    logic [AW-1:0]    lim_reg;
    logic [AW-1:0]    lim_next;
    logic             more_reg;
    logic             more_next;
    logic             rv_reg;
    logic             rv_next;
    logic [AW-1:0]    ra_reg;
    logic [AW-1:0]    ra_next;
    logic [AW-1:0]    p0_reg;
    logic [AW-1:0]    p0_next;
    logic [31:0]      key_reg;
    logic [31:0]      key_next;
    logic             search_reg;
    logic             search_next;

    logic [31:0]      mem [DEPTH];
    logic [31:0]      rdata_reg;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [31:0]      mem_wdata;

    logic             accept;
    logic [CMPW-1:0]  pos_ext;
    logic [CMPW-1:0]  cnt_ext;
    logic [AW-1:0]    req_p0;
    logic [AW-1:0]    cnt_last;
    logic [6:0]       p0_pos;
    logic [6:0]       ra_pos;
    plid_pkg::beat_t  beat;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign pos_ext  = CMPW'(request.position);
    assign cnt_ext  = CMPW'(count_reg);
    assign req_p0   = AW'(pos_ext - CMPW'(1));
    assign cnt_last = AW'(count_reg - CW'(1));
    assign p0_pos   = 7'(AW1'(p0_reg) + AW1'(1));
    assign ra_pos   = 7'(AW1'(ra_reg) + AW1'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        raddr_next  = raddr_reg;
        lim_next    = lim_reg;
        more_next   = more_reg;
        rv_next     = 1'b0;
        ra_next     = ra_reg;
        p0_next     = p0_reg;
        key_next    = key_reg;
        search_next = search_reg;
        mem_re      = 1'b0;
        mem_raddr   = raddr_reg;
        mem_we      = 1'b0;
        mem_waddr   = p0_reg;
        mem_wdata   = key_reg;
        beat        = '0;
        beat.count  = 7'(count_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    beat.valid = 1'b1;
                    unique case (request.command)
                        plid_pkg::CMD_CLEAR:
                        begin
                            count_next  = '0;
                            beat.status = plid_pkg::ST_OK;
                            beat.count  = 7'd0;
                        end
                        plid_pkg::CMD_INSERT:
                        begin
                            priority if (count_reg == CW'(DEPTH))
                                beat.status = plid_pkg::ST_FULL;
                            else if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1))
                                beat.status = plid_pkg::ST_BADPOS;
                            else
                            begin
                                beat.valid = 1'b0;
                                p0_next    = req_p0;
                                key_next   = request.value;
                                raddr_next = cnt_last;
                                lim_next   = req_p0;
                                more_next  = (CMPW'(req_p0) != cnt_ext);
                                state_next = S_UP;
                            end
                        end
                        plid_pkg::CMD_DELETE:
                        begin
                            priority if (count_reg == '0)
                                beat.status = plid_pkg::ST_EMPTY;
                            else if (pos_ext == '0 || pos_ext > cnt_ext)
                                beat.status = plid_pkg::ST_BADPOS;
                            else
                            begin
                                beat.valid = 1'b0;
                                p0_next    = req_p0;
                                raddr_next = req_p0;
                                lim_next   = cnt_last;
                                more_next  = 1'b1;
                                state_next = S_DOWN;
                            end
                        end
                        plid_pkg::CMD_SEARCH,
                        plid_pkg::CMD_READ:
                        begin
                            if (count_reg == '0)
                                beat.status = plid_pkg::ST_EMPTY;
                            else
                            begin
                                beat.valid  = 1'b0;
                                key_next    = request.value;
                                search_next = (request.command == plid_pkg::CMD_SEARCH);
                                raddr_next  = '0;
                                lim_next    = cnt_last;
                                more_next   = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            beat.status = plid_pkg::ST_BADCMD;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                if (rv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(ra_reg + AW'(1));
                    mem_wdata = rdata_reg;
                end
                if (more_reg)
                begin
                    mem_re  = 1'b1;
                    rv_next = 1'b1;
                    ra_next = raddr_reg;
                    if (raddr_reg == lim_reg)
                        more_next = 1'b0;
                    else
                        raddr_next = AW'(raddr_reg - AW'(1));
                end
                else if (!rv_reg)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = p0_reg;
                    mem_wdata     = key_reg;
                    count_next    = CW'(count_reg + CW'(1));
                    beat.valid    = 1'b1;
                    beat.status   = plid_pkg::ST_OK;
                    beat.position = p0_pos;
                    beat.value    = key_reg;
                    beat.count    = 7'(count_reg + CW'(1));
                    state_next    = S_IDLE;
                end
            end
            S_DOWN:
            begin
                if (rv_reg)
                begin
                    if (ra_reg == p0_reg)
                        key_next = rdata_reg;
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(ra_reg - AW'(1));
                        mem_wdata = rdata_reg;
                    end
                end
                if (more_reg)
                begin
                    mem_re  = 1'b1;
                    rv_next = 1'b1;
                    ra_next = raddr_reg;
                    if (raddr_reg == lim_reg)
                        more_next = 1'b0;
                    else
                        raddr_next = AW'(raddr_reg + AW'(1));
                end
                else if (!rv_reg)
                begin
                    count_next    = CW'(count_reg - CW'(1));
                    beat.valid    = 1'b1;
                    beat.status   = plid_pkg::ST_OK;
                    beat.position = p0_pos;
                    beat.value    = key_reg;
                    beat.count    = 7'(count_reg - CW'(1));
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (rv_reg)
                begin
                    beat.valid    = 1'b1;
                    beat.elem     = 1'b1;
                    beat.hit      = !search_reg || (rdata_reg == key_reg);
                    beat.status   = plid_pkg::ST_OK;
                    beat.position = ra_pos;
                    beat.value    = rdata_reg;
                end
                if (more_reg)
                begin
                    mem_re  = 1'b1;
                    rv_next = 1'b1;
                    ra_next = raddr_reg;
                    if (raddr_reg == lim_reg)
                        more_next = 1'b0;
                    else
                        raddr_next = AW'(raddr_reg + AW'(1));
                end
                else if (!rv_reg)
                begin
                    beat.valid  = 1'b1;
                    beat.fin    = 1'b1;
                    beat.status = plid_pkg::ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            more_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            more_reg  <= more_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg  <= raddr_next;
        lim_reg    <= lim_next;
        ra_reg     <= ra_next;
        p0_reg     <= p0_next;
        key_reg    <= key_next;
        search_reg <= search_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    plid_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .beat   (beat),
        .done   (done),
        .result (result)
    );

`ifndef SYNTH
    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same entry");

    a_read_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (CW'(mem_raddr) < count_reg))
        else $error("read beyond the held entries");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !mem_we)
        else $error("write during scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (count_reg == $past(count_reg)
            || count_reg == CW'($past(count_reg) + CW'(1))
            || count_reg == CW'($past(count_reg) - CW'(1))))
        else $error("entry count moved by more than one");
`endif

endmodule
